[rtl/fcw_pkg.sv]
// Shared types and constants for the FAT16 cluster chain walker.
`default_nettype none
package fcw_pkg;

   localparam logic [15:0] END_MARK = 16'hFFF8;

   localparam logic CSR_DATA_START = 1'b0;
   localparam logic CSR_SPC        = 1'b1;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_WALK = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_BAD_LINK = 2'd1,
      STAT_TOO_LONG = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LINK = 2'b10
   } walk_state_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] cluster;
      logic        last;
      status_type  status;
   } emit_type;

endpackage
`default_nettype wire

[rtl/fcw_fat_ram.sv]
// Allocation table store: one write port, one registered read port.
`default_nettype none
module fcw_fat_ram #(
   parameter int FAT_ENTRIES = 4096,
   parameter int AW          = 12
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [15:0]   wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [15:0]        rd_data
);
   logic [15:0] mem [FAT_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

[rtl/fcw_walk_ctrl.sv]
// Walk sequencer: table loads, chain following and end-of-run decisions.
`default_nettype none
module fcw_walk_ctrl #(
   parameter int FAT_ENTRIES = 4096,
   parameter int MAX_CHAIN   = 64,
   parameter int AW          = 12
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          go,
   input  wire logic          mode,
   input  wire logic [11:0]   entry_index,
   input  wire logic [15:0]   entry_value,
   input  wire logic [15:0]   start_cluster,
   input  wire logic [15:0]   link_data,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output logic [15:0]        wr_data,
   output logic               rd_en,
   output logic [AW-1:0]      rd_addr,
   output logic               walking,
   output fcw_pkg::emit_type  emit
);
   import fcw_pkg::*;

   localparam int CW = $clog2(MAX_CHAIN + 1);
   localparam logic [CW-1:0] LAST_COUNT = CW'(MAX_CHAIN - 1);

   walk_state_type state_ff, state_in;
   logic [15:0]    cur_ff, cur_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [31:0]    idx_wide;

   function automatic logic readable(input logic [15:0] c);
      return (c >= 16'd2) && ({1'b0, c} < 17'(FAT_ENTRIES));
   endfunction

   assign idx_wide = 32'(entry_index);
   assign wr_en    = go && (mode == MODE_LOAD) && (idx_wide < 32'(FAT_ENTRIES));
   assign wr_addr  = idx_wide[AW-1:0];
   assign wr_data  = entry_value;
   assign walking  = (state_ff == ST_LINK);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      rd_en        = 1'b0;
      rd_addr      = cur_ff[AW-1:0];
      emit.valid   = 1'b0;
      emit.cluster = cur_ff;
      emit.last    = 1'b0;
      emit.status  = STAT_OK;
      unique case (state_ff)
         ST_IDLE: begin
            if (go && (mode == MODE_WALK)) begin
               cur_in   = start_cluster;
               count_in = '0;
               if (start_cluster >= END_MARK) begin
                  emit.valid   = 1'b1;
                  emit.cluster = start_cluster;
                  emit.last    = 1'b1;
               end else if (!readable(start_cluster)) begin
                  emit.valid   = 1'b1;
                  emit.cluster = start_cluster;
                  emit.last    = 1'b1;
                  emit.status  = STAT_BAD_LINK;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = start_cluster[AW-1:0];
                  state_in = ST_LINK;
               end
            end
         end
         ST_LINK: begin
            emit.valid = 1'b1;
            priority if (link_data >= END_MARK) begin
               emit.last = 1'b1;
               state_in  = ST_IDLE;
            end else if (!readable(link_data)) begin
               emit.last   = 1'b1;
               emit.status = STAT_BAD_LINK;
               state_in    = ST_IDLE;
            end else if (count_ff == LAST_COUNT) begin
               emit.last   = 1'b1;
               emit.status = STAT_TOO_LONG;
               state_in    = ST_IDLE;
            end else begin
               cur_in   = link_data;
               count_in = count_ff + 1'b1;
               rd_en    = 1'b1;
               rd_addr  = link_data[AW-1:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

[rtl/fcw_sector_pipe.sv]
// Result pipeline: cluster offset multiply, then data start add.
`default_nettype none
module fcw_sector_pipe (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fcw_pkg::emit_type emit,
   input  wire logic [31:0]       data_start,
   input  wire logic [7:0]        spc,
   output logic                   pipe_busy,
   output logic                   rsp_strobe,
   output logic [15:0]            rsp_cluster_number,
   output logic [31:0]            rsp_first_sector,
   output logic                   rsp_last,
   output logic [1:0]             rsp_status
);
   import fcw_pkg::*;

   logic        s1_valid_ff;
   logic [15:0] s1_cluster_ff;
   logic [31:0] s1_prod_ff, s1_prod_in;
   logic        s1_last_ff;
   status_type  s1_status_ff;
   logic [31:0] offset;
   logic [31:0] prod_full;

   assign offset     = 32'(emit.cluster) - 32'd2;
   assign prod_full  = offset * 32'(spc);
   assign s1_prod_in = prod_full;
   assign pipe_busy  = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_strobe  <= 1'b0;
      end else begin
         s1_valid_ff <= emit.valid;
         rsp_strobe  <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_cluster_ff      <= emit.cluster;
      s1_prod_ff         <= s1_prod_in;
      s1_last_ff         <= emit.last;
      s1_status_ff       <= emit.status;
      rsp_cluster_number <= s1_cluster_ff;
      rsp_first_sector   <= s1_prod_ff + data_start;
      rsp_last           <= s1_last_ff;
      rsp_status         <= s1_status_ff;
   end
endmodule
`default_nettype wire

[rtl/fat16_cluster_chain_walker.sv]
// Top level of the FAT16 cluster chain walker.
// Usage:
//   A command is taken at a clock edge with start high and busy low.
//   req_mode 0 writes req_entry_value into table entry req_entry_index in
//   that same edge; it gives no result and busy stays low, so loads may
//   follow every cycle. Indexes past the table are ignored.
//   req_mode 1 walks the chain from req_start_cluster. One result beat per
//   cluster, rsp_strobe high for one cycle; rsp_last marks the final beat,
//   whose rsp_status tells end of chain, bad link or chain too long.
//   Timing: an out-of-range or end-marker start sends its single beat directly
//   into the result pipeline; otherwise the first beat waits for the table
//   read, and the rest follow one per cycle, set by the single table read port
//   (one read per cluster). Busy stays high while the walk runs and while the
//   first pipeline stage holds a beat; busy drops as the final beat strobes.
//   The receiver cannot stall: every beat must be taken when strobed.
//   The user must write configuration (csr_*) only while busy is low; it is
//   not enforced. Index 0 is the data region start sector, 1 sectors/cluster.
//   Reset clears the sequencer and pipeline and sets sectors per cluster to
//   1; table contents are undefined until loaded, and no clearing pass runs.
`default_nettype none
module fat16_cluster_chain_walker #(
   parameter int FAT_ENTRIES = 4096,
   parameter int MAX_CHAIN   = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_mode,
   input  wire logic [11:0] req_entry_index,
   input  wire logic [15:0] req_entry_value,
   input  wire logic [15:0] req_start_cluster,
   output logic             rsp_strobe,
   output logic [15:0]      rsp_cluster_number,
   output logic [31:0]      rsp_first_sector,
   output logic             rsp_last,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);
   import fcw_pkg::*;

   localparam int AW = $clog2(FAT_ENTRIES);

   logic [31:0]   data_start_ff;
   logic [7:0]    spc_ff;
   logic          go;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [15:0]   wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [15:0]   rd_data;
   logic          walking;
   logic          pipe_busy;
   emit_type      emit;

   assign go   = start && !busy;
   assign busy = walking || pipe_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_start_ff <= '0;
         spc_ff        <= 8'd1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DATA_START: data_start_ff <= csr_wdata;
            CSR_SPC:        spc_ff        <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   fcw_fat_ram #(
      .FAT_ENTRIES(FAT_ENTRIES),
      .AW(AW)
   ) u_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   fcw_walk_ctrl #(
      .FAT_ENTRIES(FAT_ENTRIES),
      .MAX_CHAIN(MAX_CHAIN),
      .AW(AW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .go(go),
      .mode(req_mode),
      .entry_index(req_entry_index),
      .entry_value(req_entry_value),
      .start_cluster(req_start_cluster),
      .link_data(rd_data),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .walking(walking),
      .emit(emit)
   );

   fcw_sector_pipe u_pipe (
      .clock(clock),
      .reset(reset),
      .emit(emit),
      .data_start(data_start_ff),
      .spc(spc_ff),
      .pipe_busy(pipe_busy),
      .rsp_strobe(rsp_strobe),
      .rsp_cluster_number(rsp_cluster_number),
      .rsp_first_sector(rsp_first_sector),
      .rsp_last(rsp_last),
      .rsp_status(rsp_status)
   );

   a_beat_follows_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result beat without a run in progress");

   a_mid_run_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> (rsp_status == STAT_OK))
      else $error("non-final beat carries an error status");

   a_more_to_come: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> busy)
      else $error("run ended without a final beat");

   a_no_read_while_loading: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !walking)
      else $error("table load during a walk");
endmodule
`default_nettype wire

[tb/tb_fat16_cluster_chain_walker.sv]
// Self-checking testbench: random FAT chains and config settings, beats checked against a predictor.
module tb_fat16_cluster_chain_walker;
   timeunit 1ns;
   timeprecision 1ps;

   import fcw_pkg::*;

   localparam int FAT_ENTRIES = 4096;
   localparam int MAX_CHAIN   = 64;
   localparam int QUIET_LIMIT = 1000;
   localparam int PHASE_ITEMS = 58;

   typedef struct {
      logic        mode;
      logic [11:0] index;
      logic [15:0] value;
      logic [15:0] first;
   } command_type;

   typedef struct {
      logic [15:0] cluster;
      logic [31:0] sector;
      logic        last;
      status_type  status;
   } beat_type;

   class walk_scoreboard;
      logic [15:0] fat_copy [FAT_ENTRIES];
      bit          loaded [FAT_ENTRIES];
      logic [31:0] data_start;
      logic [7:0]  spc;
      beat_type    expected_beats [$];
      int          errors;

      function new();
         data_start = '0;
         spc        = 8'd1;
         errors     = 0;
      endfunction

      function void set_reg(logic index, logic [31:0] value);
         if (index == CSR_DATA_START) begin
            data_start = value;
         end else begin
            spc = value[7:0];
         end
      endfunction

      function logic [31:0] sector_of(logic [15:0] cluster);
         logic [31:0] offset;
         offset = ({16'd0, cluster} - 32'd2) * {24'd0, spc};
         return offset + data_start;
      endfunction

      function bit in_table(logic [15:0] cluster);
         return cluster >= 16'd2 && cluster < FAT_ENTRIES;
      endfunction

      function beat_type make_beat(logic [15:0] cluster, logic last, status_type status);
         beat_type b;
         b.cluster = cluster;
         b.sector  = sector_of(cluster);
         b.last    = last;
         b.status  = status;
         return b;
      endfunction

      // Walks the chain from first; returns 0 if it would read an entry never loaded.
      // With record set, the beats of the walk are queued as expectations.
      function bit follow_chain(logic [15:0] first, bit record);
         beat_type    run [$];
         logic [15:0] cur;
         logic [15:0] link;
         bit          done;
         cur  = first;
         done = 0;
         if (cur >= END_MARK) begin
            run.push_back(make_beat(cur, 1'b1, STAT_OK));
         end else if (!in_table(cur)) begin
            run.push_back(make_beat(cur, 1'b1, STAT_BAD_LINK));
         end else begin
            while (!done) begin
               if (!loaded[cur]) return 0;
               link = fat_copy[cur];
               if (link >= END_MARK) begin
                  run.push_back(make_beat(cur, 1'b1, STAT_OK));
                  done = 1;
               end else if (!in_table(link)) begin
                  run.push_back(make_beat(cur, 1'b1, STAT_BAD_LINK));
                  done = 1;
               end else if (run.size() + 1 >= MAX_CHAIN) begin
                  run.push_back(make_beat(cur, 1'b1, STAT_TOO_LONG));
                  done = 1;
               end else begin
                  run.push_back(make_beat(cur, 1'b0, STAT_OK));
                  cur = link;
               end
            end
         end
         if (record) begin
            foreach (run[i]) expected_beats.push_back(run[i]);
         end
         return 1;
      endfunction

      function void note_input(command_type cmd);
         if (cmd.mode == MODE_LOAD) begin
            fat_copy[cmd.index] = cmd.value;
            loaded[cmd.index]   = 1;
         end else begin
            void'(follow_chain(cmd.first, 1));
         end
      endfunction

      function void check_result(logic [15:0] cluster, logic [31:0] sector, logic last,
                                 logic [1:0] status);
         beat_type want;
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: cluster_number %0d", cluster);
            errors++;
            return;
         end
         want = expected_beats.pop_front();
         if (cluster !== want.cluster) begin
            $error("cluster_number: expected %0d, actual %0d", want.cluster, cluster);
            errors++;
         end
         if (sector !== want.sector) begin
            $error("first_sector: expected 0x%08h, actual 0x%08h", want.sector, sector);
            errors++;
         end
         if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            errors++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
         end
      endfunction

      function bit drained();
         return expected_beats.size() == 0;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_mode = MODE_LOAD;
   logic [11:0] req_entry_index = '0;
   logic [15:0] req_entry_value = '0;
   logic [15:0] req_start_cluster = '0;
   logic        rsp_strobe;
   logic [15:0] rsp_cluster_number;
   logic [31:0] rsp_first_sector;
   logic        rsp_last;
   logic [1:0]  rsp_status;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = CSR_DATA_START;
   logic [31:0] csr_wdata = '0;

   walk_scoreboard board;
   int             sent = 0;
   int             quiet_cycles = 0;

   fat16_cluster_chain_walker #(
      .FAT_ENTRIES(FAT_ENTRIES),
      .MAX_CHAIN  (MAX_CHAIN)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_entry_index   (req_entry_index),
      .req_entry_value   (req_entry_value),
      .req_start_cluster (req_start_cluster),
      .rsp_strobe        (rsp_strobe),
      .rsp_cluster_number(rsp_cluster_number),
      .rsp_first_sector  (rsp_first_sector),
      .rsp_last          (rsp_last),
      .rsp_status        (rsp_status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // beat checking and watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_strobe) begin
            board.check_result(rsp_cluster_number, rsp_first_sector, rsp_last, rsp_status);
         end
         if (rsp_strobe || (start && !busy)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("fat16_cluster_chain_walker regression: fail");
            $finish;
         end
      end
   end

   function automatic int pick_gap(int idle_pct);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
      return gap;
   endfunction

   task automatic send_item(command_type cmd, int idle_pct);
      int gap;
      gap = pick_gap(idle_pct);
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start             = 1'b1;
      req_mode          = cmd.mode;
      req_entry_index   = cmd.index;
      req_entry_value   = cmd.value;
      req_start_cluster = cmd.first;
      do @(posedge clock); while (busy);
      board.note_input(cmd);
      sent++;
   endtask

   task automatic load_entry(logic [15:0] index, logic [15:0] value, int idle_pct);
      command_type cmd;
      cmd.mode  = MODE_LOAD;
      cmd.index = index[11:0];
      cmd.value = value;
      cmd.first = 16'($urandom);
      send_item(cmd, idle_pct);
   endtask

   task automatic walk_from(logic [15:0] first, int idle_pct);
      command_type cmd;
      cmd.mode  = MODE_WALK;
      cmd.index = 12'($urandom);
      cmd.value = 16'($urandom);
      cmd.first = first;
      send_item(cmd, idle_pct);
   endtask

   // stop sending and let every expected beat arrive
   task automatic drain_all();
      @(negedge clock);
      start = 1'b0;
      while (!board.drained()) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic index, logic [31:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(posedge clock);
      board.set_reg(index, value);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // builds a chain with a random ending, loads it out of order, then walks it
   task automatic run_chain(int idle_pct);
      logic [15:0] nodes [$];
      logic [15:0] links [$];
      int          order [$];
      int          len;
      int          j;
      int          tmp;
      logic [15:0] mid;
      len = ($urandom_range(7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
         nodes.push_back(16'($urandom_range(2, FAT_ENTRIES - 1)));
         order.push_back(i);
      end
      for (int i = 0; i < len - 1; i++) links.push_back(nodes[i + 1]);
      case ($urandom_range(3))
         0: links.push_back(16'($urandom_range(16'hFFF8, 16'hFFFF)));
         1: links.push_back(16'($urandom_range(1)));
         2: links.push_back(16'($urandom_range(FAT_ENTRIES, 16'hFFF7)));
         default: links.push_back(nodes[$urandom_range(len - 1)]);
      endcase
      for (int i = len - 1; i > 0; i--) begin
         j        = $urandom_range(i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      foreach (order[i]) load_entry(nodes[order[i]], links[order[i]], idle_pct);
      if ($urandom_range(24) == 0) drain_all();
      if (board.follow_chain(nodes[0], 0)) walk_from(nodes[0], idle_pct);
      mid = nodes[$urandom_range(len - 1)];
      if ($urandom_range(2) == 0 && board.follow_chain(mid, 0)) walk_from(mid, idle_pct);
   endtask

   task automatic stray_walk(int idle_pct);
      logic [15:0] first;
      case ($urandom_range(3))
         0: first = 16'($urandom_range(16'hFFF8, 16'hFFFF));
         1: first = 16'($urandom_range(1));
         2: first = 16'($urandom_range(FAT_ENTRIES, 16'hFFF7));
         default: begin
            first = 16'($urandom_range(2, FAT_ENTRIES - 1));
            if (!board.follow_chain(first, 0)) first = 16'($urandom_range(FAT_ENTRIES, 16'hFFF7));
         end
      endcase
      walk_from(first, idle_pct);
   endtask

   initial begin
      logic [31:0] start_set [4];
      logic [31:0] spc_set [4];
      int          idle_set [4];
      int          target;
      int          pick;
      board     = new();
      start_set = '{32'hFFFF_FFFF, 32'($urandom), 32'h8000_0000, 32'($urandom)};
      spc_set   = '{32'd128, 32'($urandom_range(1, 128)), 32'd0, 32'd255};
      idle_set  = '{0, 81, 13, 0};

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      write_reg(CSR_DATA_START, 32'd0);
      write_reg(CSR_SPC, 32'd1);

      // directed: table extremes, each way a walk can end, bad and end-marker starts
      load_entry(16'd0, 16'h0000, 0);
      load_entry(16'd4095, 16'hFFFF, 0);
      load_entry(16'd2, 16'd3, 0);
      load_entry(16'd3, 16'd2, 0);
      load_entry(16'd10, 16'd11, 0);
      load_entry(16'd11, 16'hFFF8, 0);
      load_entry(16'd20, 16'd21, 0);
      load_entry(16'd21, 16'd1, 0);
      load_entry(16'd30, 16'd4096, 0);
      load_entry(16'd40, 16'hFFF7, 0);
      walk_from(16'd4095, 0);
      walk_from(16'd2, 0);
      walk_from(16'd10, 0);
      walk_from(16'd20, 0);
      walk_from(16'd30, 0);
      walk_from(16'd40, 0);
      walk_from(16'hFFF8, 0);
      walk_from(16'hFFFF, 0);
      walk_from(16'd0, 0);
      walk_from(16'd1, 0);
      walk_from(16'd4096, 0);
      walk_from(16'hFFF7, 0);

      for (int p = 0; p < 4; p++) begin
         drain_all();
         write_reg(CSR_DATA_START, start_set[p]);
         write_reg(CSR_SPC, spc_set[p]);
         target = sent + PHASE_ITEMS;
         while (sent < target) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
               run_chain(idle_set[p]);
            end else if (pick < 85) begin
               load_entry(16'($urandom_range(FAT_ENTRIES - 1)), 16'($urandom), idle_set[p]);
            end else begin
               stray_walk(idle_set[p]);
            end
         end
      end

      drain_all();
      if (board.errors == 0 && board.drained()) begin
         $display("fat16_cluster_chain_walker regression: pass");
      end else begin
         $display("fat16_cluster_chain_walker regression: fail");
      end
      $finish;
   end
endmodule
